[rtl/smu_pkg.sv]
// Shared types, constants and a helper function for the momentum update core.
`timescale 1ns / 1ps
package smu_pkg;

  localparam int IDX_W    = 12;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int DATA_W   = 32;
  localparam int COEF_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [COEF_W-1:0] MOMENTUM_RST      = 16'd58982;
  localparam logic [COEF_W-1:0] LEARNING_RATE_RST = 16'd655;
  localparam logic [COEF_W-1:0] WEIGHT_DECAY_RST  = 16'd0;

  // Saturation bounds in the widest intermediate (34-bit signed)
  localparam logic signed [DATA_W+1:0] SAT_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [DATA_W+1:0] SAT_MIN = 34'sh3_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOMENTUM      = 2'd0,
    REG_LEARNING_RATE = 2'd1,
    REG_WEIGHT_DECAY  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] mu;
    logic [COEF_W-1:0] lr;
    logic [COEF_W-1:0] wd;
  } coef_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } vel_rd_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } vel_wr_t;

  typedef struct packed {
    logic advance;
    logic accept;
  } pipe_ctl_t;

  typedef struct packed {
    logic p4_valid;
    logic hazard;
  } pipe_stat_t;

  typedef struct packed {
    logic              clip;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Clip a 34-bit signed value into the 32-bit signed range
  function automatic sat_t sat32(input logic signed [DATA_W+1:0] x);
    sat_t r;
    r.clip = 1'b0;
    r.val  = x[DATA_W-1:0];
    if (x > SAT_MAX) begin
      r.clip = 1'b1;
      r.val  = SAT_MAX[DATA_W-1:0];
    end else if (x < SAT_MIN) begin
      r.clip = 1'b1;
      r.val  = SAT_MIN[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/smu_vel_store.sv]
// Velocity memory: one synchronous write port, one registered read port, clear sweep.
`timescale 1ns / 1ps
module smu_vel_store import smu_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  vel_rd_t           rd,
  input  vel_wr_t           wr,
  output logic [DATA_W-1:0] rd_data,
  output logic              clearing
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_cnt;

  // Sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  // Read-first: a same-edge write is forwarded by the pipeline
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr[AW-1:0]];
    end
  end

endmodule

[rtl/smu_update_pipe.sv]
// Four-stage update datapath with read-modify-write forwarding and hazard detect.
`timescale 1ns / 1ps
module smu_update_pipe import smu_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctl_t         ctl,
  input  coef_t             coef,
  input  logic [IDX_W-1:0]  element_index,
  input  logic [DATA_W-1:0] weight,
  input  logic [DATA_W-1:0] gradient,
  input  logic              is_bias,
  input  logic              first_use,
  input  logic [DATA_W-1:0] rd_data,
  output vel_rd_t           rd,
  output vel_wr_t           wr,
  output pipe_stat_t        stat,
  output logic [DATA_W-1:0] res_weight,
  output logic              res_clip
);

  // Stage 1: input captured, velocity read in flight
  logic                     p1_valid;
  logic [IDX_W-1:0]         p1_idx;
  logic                     p1_inr;
  logic                     p1_first;
  logic                     p1_bias;
  logic signed [DATA_W-1:0] p1_w;
  logic signed [DATA_W-1:0] p1_g;
  // Stage 2: decay product, resolved velocity
  logic                     p2_valid;
  logic [IDX_W-1:0]         p2_idx;
  logic                     p2_inr;
  logic signed [DATA_W-1:0] p2_w;
  logic signed [DATA_W-1:0] p2_g;
  logic signed [DATA_W-1:0] p2_vel;
  logic signed [47:0]       p2_dprod;
  // Stage 3: step and momentum products
  logic                     p3_valid;
  logic [IDX_W-1:0]         p3_idx;
  logic                     p3_inr;
  logic signed [DATA_W-1:0] p3_w;
  logic signed [48:0]       p3_sprod;
  logic signed [47:0]       p3_mprod;
  // Stage 4: new velocity
  logic                     p4_valid;
  logic [IDX_W-1:0]         p4_idx;
  logic                     p4_inr;
  logic signed [DATA_W-1:0] p4_w;
  logic signed [DATA_W-1:0] p4_vn;
  logic                     p4_vclip;

  logic                     in_inr;
  logic signed [16:0]       mu_s;
  logic signed [16:0]       lr_s;
  logic signed [16:0]       wd_s;
  logic signed [DATA_W-1:0] vel_sel;
  logic signed [DATA_W-1:0] decay;
  logic signed [DATA_W:0]   dsum;
  logic signed [DATA_W:0]   step;
  logic signed [DATA_W-1:0] mom;
  logic signed [DATA_W+1:0] vsum;
  logic signed [DATA_W+1:0] wdiff;
  sat_t                     vsat;
  sat_t                     wsat;

  assign in_inr = 32'(element_index) < DEPTH;
  assign mu_s   = {1'b0, coef.mu};
  assign lr_s   = {1'b0, coef.lr};
  assign wd_s   = {1'b0, coef.wd};

  // Same slot right behind an item still in stage 1: its velocity is not ready yet
  assign stat.hazard   = p1_valid && p1_inr && !first_use && (p1_idx == element_index);
  assign stat.p4_valid = p4_valid;

  assign rd.en   = ctl.accept;
  assign rd.addr = element_index;

  // Stage 3 arithmetic
  assign step = p3_sprod[48:16];
  assign mom  = p3_mprod[47:16];
  assign vsum = 34'(mom) + 34'(step);
  assign vsat = sat32(vsum);

  assign wr.en   = ctl.advance && p3_valid && p3_inr;
  assign wr.addr = p3_idx;
  assign wr.data = vsat.val;

  // Stage 2 arithmetic
  assign decay = p2_dprod[47:16];
  assign dsum  = 33'(p2_g) + 33'(decay);

  // Stage 4 arithmetic
  assign wdiff      = 34'(p4_w) - 34'(p4_vn);
  assign wsat       = sat32(wdiff);
  assign res_weight = wsat.val;
  assign res_clip   = wsat.clip || p4_vclip;

  // Velocity for the item leaving stage 1: newest in-flight write wins
  always_comb begin
    priority if (!p1_inr || p1_first) begin
      vel_sel = '0;
    end else if (p3_valid && p3_inr && (p3_idx == p1_idx)) begin
      vel_sel = vsat.val;
    end else if (p4_valid && p4_inr && (p4_idx == p1_idx)) begin
      vel_sel = p4_vn;
    end else begin
      vel_sel = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (ctl.advance) begin
      p1_valid <= ctl.accept;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      p1_idx   <= element_index;
      p1_inr   <= in_inr;
      p1_first <= first_use;
      p1_bias  <= is_bias;
      p1_w     <= weight;
      p1_g     <= gradient;

      p2_idx   <= p1_idx;
      p2_inr   <= p1_inr;
      p2_w     <= p1_w;
      p2_g     <= p1_g;
      p2_vel   <= vel_sel;
      p2_dprod <= p1_bias ? '0 : 48'(p1_w) * 48'(wd_s);

      p3_idx   <= p2_idx;
      p3_inr   <= p2_inr;
      p3_w     <= p2_w;
      p3_sprod <= 49'(dsum) * 49'(lr_s);
      p3_mprod <= 48'(p2_vel) * 48'(mu_s);

      p4_idx   <= p3_idx;
      p4_inr   <= p3_inr;
      p4_w     <= p3_w;
      p4_vn    <= vsat.val;
      p4_vclip <= vsat.clip;
    end
  end

endmodule

[rtl/sgd_momentum_update_core.sv]
// Top level of the SGD momentum update core: config registers, handshakes, output beat.
`timescale 1ns / 1ps
// Streams one parameter element per beat and returns its updated weight:
// v = mu*v + lr*(grad + w*wd) (decay dropped for biases), w' = w - v, both
// clipped to signed Q16.16 with the saturated flag set on any clip. The
// velocity of each element lives in an on-chip memory of min(VELOCITY_DEPTH,
// 4096) words; an index at or beyond VELOCITY_DEPTH reads zero and is not
// stored. Throughput is one beat per cycle while the output is not stalled.
// The velocity read-modify-write loop runs through the momentum multiplier,
// so an in-range element index that repeats on the very next beat (without
// first_use) is held off while the earlier element is in stage 1; a later
// repeat is forwarded at full rate. Each beat passes through stages 1 to 4
// and then the output register. After reset every memory word is swept to
// zero, during which in_ready stays low; configuration writes are taken at
// any time and should only be issued while the core is drained.
module sgd_momentum_update_core import smu_pkg::*; #(
  parameter int VELOCITY_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  // input beat
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     element_index,
  input  logic [DATA_W-1:0]    weight,
  input  logic [DATA_W-1:0]    gradient,
  input  logic                 is_bias,
  input  logic                 first_use,
  // output beat
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    new_weight,
  output logic                 saturated
);

  // Only 4096 slots are addressable through element_index
  localparam int MEM_DEPTH = (VELOCITY_DEPTH < IDX_SPAN) ? VELOCITY_DEPTH : IDX_SPAN;

  coef_t             coef;
  pipe_ctl_t         ctl;
  pipe_stat_t        stat;
  vel_rd_t           rd;
  vel_wr_t           wr;
  logic [DATA_W-1:0] rd_data;
  logic              clearing;
  logic [DATA_W-1:0] res_weight;
  logic              res_clip;

  // Config registers accept a write every cycle; unknown indexes drop the beat
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.mu <= MOMENTUM_RST;
      coef.lr <= LEARNING_RATE_RST;
      coef.wd <= WEIGHT_DECAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOMENTUM:      coef.mu <= cfg_data;
        REG_LEARNING_RATE: coef.lr <= cfg_data;
        REG_WEIGHT_DECAY:  coef.wd <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves in lockstep; it only holds when stage 4 has a result
  // and the output register is still occupied by an untaken beat.
  assign ctl.advance = !stat.p4_valid || !out_valid || out_ready;
  assign in_ready    = ctl.advance && !clearing && !stat.hazard;
  assign ctl.accept  = in_valid && in_ready;

  smu_vel_store #(
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  smu_update_pipe #(
    .DEPTH (MEM_DEPTH)
  ) u_pipe (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .coef          (coef),
    .element_index (element_index),
    .weight        (weight),
    .gradient      (gradient),
    .is_bias       (is_bias),
    .first_use     (first_use),
    .rd_data       (rd_data),
    .rd            (rd),
    .wr            (wr),
    .stat          (stat),
    .res_weight    (res_weight),
    .res_clip      (res_clip)
  );

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance && stat.p4_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && stat.p4_valid) begin
      new_weight <= res_weight;
      saturated  <= res_clip;
    end
  end

  // Pipeline is empty during the clear sweep, so no update may hit the memory
  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr.en)
    else $error("velocity update written during clear sweep");

  // A full stage 4 behind a stalled output must block new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stat.p4_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is stalled");

  // Clear sweep starts right out of reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> clearing)
    else $error("clear sweep not running after reset");

endmodule
